// File: hw/rtl/phaser_pkg.sv
// Package with shared types, register indexes, state codes and saturation helpers for the phaser.
package phaser_pkg;

   localparam int DEF_MAX_STAGES = 16;
   localparam int DEF_KNEE       = 28000;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 15;

   localparam logic [CSR_INDEX_W-1:0] REG_STAGE_COUNT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FEEDBACK    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MIX         = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_COEF        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SIXTEEN_BIT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SIGNED      = 3'd5;

   localparam logic [4:0]  RST_STAGE_COUNT = 5'd1;
   localparam logic [14:0] RST_FEEDBACK    = 15'd22936;
   localparam logic [14:0] RST_MIX         = 15'd0;
   localparam logic [14:0] RST_COEF        = 15'd32767;

   localparam logic [14:0] BYPASS_LIMIT = 15'd328;
   localparam logic [14:0] FB_MIN       = 15'd3276;
   localparam logic [14:0] FB_MAX       = 15'd29490;
   localparam logic [7:0]  SIGN_FLIP_8  = 8'h80;
   localparam logic [15:0] SIGN_FLIP_16 = 16'h8000;

   localparam int STATE_W = 4;
   localparam logic [STATE_W-1:0] ST_IDLE    = 4'd0;
   localparam logic [STATE_W-1:0] ST_FB_MUL  = 4'd1;
   localparam logic [STATE_W-1:0] ST_FB_ADD  = 4'd2;
   localparam logic [STATE_W-1:0] ST_AP_MUL1 = 4'd3;
   localparam logic [STATE_W-1:0] ST_AP_ADD1 = 4'd4;
   localparam logic [STATE_W-1:0] ST_AP_MUL2 = 4'd5;
   localparam logic [STATE_W-1:0] ST_AP_ADD2 = 4'd6;
   localparam logic [STATE_W-1:0] ST_WET_MUL = 4'd7;
   localparam logic [STATE_W-1:0] ST_WET_ADD = 4'd8;
   localparam logic [STATE_W-1:0] ST_LIM_MUL = 4'd9;
   localparam logic [STATE_W-1:0] ST_LIM_DIV = 4'd10;
   localparam logic [STATE_W-1:0] ST_FINISH  = 4'd11;

   typedef struct packed {
      logic [4:0]  stage_count;
      logic [14:0] feedback_q15;
      logic [14:0] mix_q15;
      logic [14:0] allpass_coef_q15;
      logic        sixteen_bit;
      logic        signed_samples;
   } cfg_type;

   typedef struct packed {
      logic [STATE_W-1:0] op;
      logic               accept;
      logic               rsp_load;
   } cmd_type;

   typedef struct packed {
      logic bypass;
      logic last_stage;
   } status_type;

   function automatic logic signed [17:0] sext16(input logic signed [15:0] a);
      return {{2{a[15]}}, a};
   endfunction

   function automatic logic signed [15:0] sat18(input logic signed [17:0] v);
      logic signed [15:0] r;
      if (v > 18'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -18'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   function automatic logic signed [15:0] q15_sat(input logic signed [35:0] p);
      logic signed [20:0] s;
      logic signed [15:0] r;
      s = p[35:15];
      if (s > 21'sd32767) begin
         r = 16'sh7fff;
      end else if (s < -21'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = s[15:0];
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/phaser_allpass_cascade_top.sv
// Top level of the phaser: configuration registers, sequencer and datapath.
//
// The block takes one audio sample per transfer on the req_ channel (valid and
// ready) together with a channel flag, and returns one sample per transfer on
// the rsp_ channel. Settings are written on the csr_ channel, which is always
// ready; write it only while no sample is in flight. Writing the stage count
// also clears the all-pass stage memories of both channels.
// A processed sample steps through the single shared multiplier, which each of the N
// stages in use takes twice, with an add step after each product. A bypassed sample
// goes from its transfer in straight to the final step. The result appears on rsp_
// when it leaves the final step. While a result waits for the receiver, the next
// sample is accepted and processed; it then waits in its final step until the
// output register is free. Reset clears the feedback words and stage memories and
// restores the default settings.
module phaser_allpass_cascade_top #(
   parameter int MAX_STAGES = phaser_pkg::DEF_MAX_STAGES,
   parameter int KNEE       = phaser_pkg::DEF_KNEE
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [15:0]                       req_in_sample,
   input  logic                              req_right_channel,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [15:0]                       rsp_out_sample,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [phaser_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [phaser_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   phaser_pkg::cfg_type    cfg_ff;
   phaser_pkg::cmd_type    cmd;
   phaser_pkg::status_type status;
   logic                   csr_write;
   logic                   mem_clear;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign mem_clear = csr_write && (csr_index == phaser_pkg::REG_STAGE_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stage_count      <= phaser_pkg::RST_STAGE_COUNT;
         cfg_ff.feedback_q15     <= phaser_pkg::RST_FEEDBACK;
         cfg_ff.mix_q15          <= phaser_pkg::RST_MIX;
         cfg_ff.allpass_coef_q15 <= phaser_pkg::RST_COEF;
         cfg_ff.sixteen_bit      <= 1'b1;
         cfg_ff.signed_samples   <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            phaser_pkg::REG_STAGE_COUNT: cfg_ff.stage_count      <= csr_wdata[4:0];
            phaser_pkg::REG_FEEDBACK:    cfg_ff.feedback_q15     <= csr_wdata;
            phaser_pkg::REG_MIX:         cfg_ff.mix_q15          <= csr_wdata;
            phaser_pkg::REG_COEF:        cfg_ff.allpass_coef_q15 <= csr_wdata;
            phaser_pkg::REG_SIXTEEN_BIT: cfg_ff.sixteen_bit      <= csr_wdata[0];
            phaser_pkg::REG_SIGNED:      cfg_ff.signed_samples   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   phaser_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   phaser_dp #(
      .MAX_STAGES (MAX_STAGES),
      .KNEE       (KNEE)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .mem_clear         (mem_clear),
      .cmd               (cmd),
      .status            (status),
      .req_in_sample     (req_in_sample),
      .req_right_channel (req_right_channel),
      .rsp_out_sample    (rsp_out_sample)
   );

endmodule

// File: hw/rtl/phaser_ctrl.sv
// Phaser sequencer: runs feedback, stages, mix and limiter per sample unless bypassed.
module phaser_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  phaser_pkg::status_type status,
   output phaser_pkg::cmd_type    cmd
);

   logic [phaser_pkg::STATE_W-1:0] state_ff;
   logic [phaser_pkg::STATE_W-1:0] state_in;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;

   assign req_ready = (state_ff == phaser_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.op       = state_ff;
      case (state_ff)
         phaser_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = status.bypass ? phaser_pkg::ST_FINISH : phaser_pkg::ST_FB_MUL;
            end
         end
         phaser_pkg::ST_FB_MUL:  state_in = phaser_pkg::ST_FB_ADD;
         phaser_pkg::ST_FB_ADD:  state_in = phaser_pkg::ST_AP_MUL1;
         phaser_pkg::ST_AP_MUL1: state_in = phaser_pkg::ST_AP_ADD1;
         phaser_pkg::ST_AP_ADD1: state_in = phaser_pkg::ST_AP_MUL2;
         phaser_pkg::ST_AP_MUL2: state_in = phaser_pkg::ST_AP_ADD2;
         phaser_pkg::ST_AP_ADD2: begin
            state_in = status.last_stage ? phaser_pkg::ST_WET_MUL : phaser_pkg::ST_AP_MUL1;
         end
         phaser_pkg::ST_WET_MUL: state_in = phaser_pkg::ST_WET_ADD;
         phaser_pkg::ST_WET_ADD: state_in = phaser_pkg::ST_LIM_MUL;
         phaser_pkg::ST_LIM_MUL: state_in = phaser_pkg::ST_LIM_DIV;
         phaser_pkg::ST_LIM_DIV: state_in = phaser_pkg::ST_FINISH;
         phaser_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = phaser_pkg::ST_IDLE;
            end
         end
         default: state_in = phaser_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= phaser_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_last_stage_exits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == phaser_pkg::ST_AP_ADD2 && status.last_stage)
      |=> state_ff == phaser_pkg::ST_WET_MUL)
      else $error("stage loop did not exit after the last stage");

   a_bypass_skips: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && status.bypass) |=> state_ff == phaser_pkg::ST_FINISH)
      else $error("bypass sample did not go straight to the output");

   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == phaser_pkg::ST_FINISH && rsp_valid_ff && !rsp_ready)
      |=> (state_ff == phaser_pkg::ST_FINISH && rsp_valid_ff))
      else $error("result overwrote an output that was not yet taken");

endmodule

// File: hw/rtl/phaser_dp.sv
// Datapath for the phaser: shared multiplier, stage memory, feedback words and limiter.
module phaser_dp #(
   parameter int MAX_STAGES = phaser_pkg::DEF_MAX_STAGES,
   parameter int KNEE       = phaser_pkg::DEF_KNEE
) (
   input  logic                   clock,
   input  logic                   reset,
   input  phaser_pkg::cfg_type    cfg,
   input  logic                   mem_clear,
   input  phaser_pkg::cmd_type    cmd,
   output phaser_pkg::status_type status,
   input  logic [15:0]            req_in_sample,
   input  logic                   req_right_channel,
   output logic [15:0]            rsp_out_sample
);

   localparam int DEPTH       = 2 * MAX_STAGES;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(MAX_STAGES + 1);
   localparam int LIMIT_SCALE = (65535 * (32768 - KNEE)) / (65536 - KNEE);
   localparam logic signed [17:0] KNEE_S  = 18'(KNEE);
   localparam logic signed [17:0] SCALE_S = 18'(LIMIT_SCALE);

   logic [15:0]        raw_ff;
   logic signed [15:0] dry_ff;
   logic               ch_ff;
   logic               bypass_ff;
   logic signed [15:0] word_ff;
   logic signed [15:0] ap_ff;
   logic signed [35:0] prod_ff;
   logic signed [17:0] v_ff;
   logic signed [15:0] res_ff;
   logic [CNT_W-1:0]   stage_ff;
   logic [15:0]        rsp_out_sample_ff;
   logic signed [15:0] fbw_ff [2];

   logic [15:0]        allpass_ff [DEPTH];
   logic [DEPTH-1:0]   valid_ff;
   logic [15:0]        rd_data_ff;
   logic               rd_valid_ff;

   logic [15:0]        raw_in;
   logic [7:0]         u8;
   logic signed [15:0] dry_in;
   logic [14:0]        fb_clamped;
   logic [CNT_W-1:0]   stages_eff;
   logic [ADDR_W-1:0]  addr;
   logic               mem_we;
   logic signed [15:0] mem_wdata;
   logic signed [15:0] rd_mem;
   logic signed [17:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [35:0] prod_in;
   logic signed [17:0] mag;
   logic               lim_pos;
   logic               lim_neg;
   logic [31:0]        div_x;
   logic [31:0]        div_s;
   logic [15:0]        div_q1;
   logic [31:0]        div_r;
   logic [15:0]        div_q;
   logic signed [17:0] lim_v;
   logic [15:0]        out_fmt;

   always_comb begin
      raw_in = cfg.sixteen_bit ? req_in_sample : {8'h00, req_in_sample[7:0]};
      u8     = raw_in[7:0] ^ (cfg.signed_samples ? 8'h00 : phaser_pkg::SIGN_FLIP_8);
      if (cfg.sixteen_bit) begin
         dry_in = raw_in ^ (cfg.signed_samples ? 16'h0000 : phaser_pkg::SIGN_FLIP_16);
      end else begin
         dry_in = {{8{u8[7]}}, u8};
      end
   end

   always_comb begin
      if (cfg.feedback_q15 < phaser_pkg::FB_MIN) begin
         fb_clamped = phaser_pkg::FB_MIN;
      end else if (cfg.feedback_q15 > phaser_pkg::FB_MAX) begin
         fb_clamped = phaser_pkg::FB_MAX;
      end else begin
         fb_clamped = cfg.feedback_q15;
      end
      if (cfg.stage_count == 5'd0) begin
         stages_eff = CNT_W'(1);
      end else if (32'(cfg.stage_count) > 32'(MAX_STAGES)) begin
         stages_eff = CNT_W'(MAX_STAGES);
      end else begin
         stages_eff = CNT_W'(cfg.stage_count);
      end
   end

   assign status.bypass     = (cfg.mix_q15 <= phaser_pkg::BYPASS_LIMIT);
   assign status.last_stage = (({1'b0, stage_ff} + 1'b1) == {1'b0, stages_eff});

   assign addr = ch_ff ? (ADDR_W'(MAX_STAGES) + ADDR_W'(stage_ff)) : ADDR_W'(stage_ff);
   assign mem_we    = (cmd.op == phaser_pkg::ST_AP_ADD2);
   assign mem_wdata = phaser_pkg::sat18(phaser_pkg::sext16(phaser_pkg::q15_sat(prod_ff))
                                        + phaser_pkg::sext16(word_ff));
   assign rd_mem    = rd_valid_ff ? rd_data_ff : 16'sh0000;

   always_comb begin
      lim_pos = (v_ff > KNEE_S);
      lim_neg = (v_ff < -KNEE_S);
      if (lim_pos) begin
         mag = v_ff - KNEE_S;
      end else if (lim_neg) begin
         mag = -v_ff - KNEE_S;
      end else begin
         mag = 18'sd0;
      end
   end

   always_comb begin
      mul_a = 18'sd0;
      mul_b = 18'sd0;
      case (cmd.op)
         phaser_pkg::ST_FB_MUL: begin
            mul_a = phaser_pkg::sext16(fbw_ff[ch_ff]);
            mul_b = {3'b000, fb_clamped};
         end
         phaser_pkg::ST_AP_MUL1: begin
            mul_a = phaser_pkg::sext16(word_ff);
            mul_b = -$signed({3'b000, cfg.allpass_coef_q15});
         end
         phaser_pkg::ST_AP_MUL2: begin
            mul_a = phaser_pkg::sext16(ap_ff);
            mul_b = {3'b000, cfg.allpass_coef_q15};
         end
         phaser_pkg::ST_WET_MUL: begin
            mul_a = phaser_pkg::sext16(word_ff);
            mul_b = {3'b000, cfg.mix_q15};
         end
         phaser_pkg::ST_LIM_MUL: begin
            mul_a = mag;
            mul_b = SCALE_S;
         end
         default: begin
            mul_a = 18'sd0;
            mul_b = 18'sd0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Division by 65535 through a shifted reciprocal and one correction step.
   always_comb begin
      div_x  = prod_ff[31:0];
      div_s  = div_x + {16'h0000, div_x[31:16]};
      div_q1 = div_s[31:16];
      div_r  = div_x - {div_q1, 16'h0000} + {16'h0000, div_q1};
      div_q  = (div_r >= 32'd65535) ? (div_q1 + 16'd1) : div_q1;
      if (lim_pos) begin
         lim_v = KNEE_S + $signed({2'b00, div_q});
      end else if (lim_neg) begin
         lim_v = -KNEE_S - $signed({2'b00, div_q});
      end else begin
         lim_v = v_ff;
      end
   end

   always_comb begin
      if (cfg.sixteen_bit) begin
         out_fmt = res_ff ^ (cfg.signed_samples ? 16'h0000 : phaser_pkg::SIGN_FLIP_16);
      end else begin
         out_fmt = {8'h00, res_ff[7:0] ^ (cfg.signed_samples ? 8'h00 : phaser_pkg::SIGN_FLIP_8)};
      end
   end

   assign rsp_out_sample = rsp_out_sample_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         allpass_ff[addr] <= mem_wdata;
      end
      rd_data_ff <= allpass_ff[addr];
   end

   always_ff @(posedge clock) begin
      if (reset || mem_clear) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_we) begin
            valid_ff[addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fbw_ff[0] <= 16'sh0000;
         fbw_ff[1] <= 16'sh0000;
      end else if (mem_we && status.last_stage) begin
         fbw_ff[ch_ff] <= ap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         raw_ff    <= raw_in;
         dry_ff    <= dry_in;
         ch_ff     <= req_right_channel;
         bypass_ff <= status.bypass;
         stage_ff  <= '0;
      end
      case (cmd.op)
         phaser_pkg::ST_FB_MUL,
         phaser_pkg::ST_AP_MUL1,
         phaser_pkg::ST_AP_MUL2,
         phaser_pkg::ST_WET_MUL,
         phaser_pkg::ST_LIM_MUL: prod_ff <= prod_in;
         phaser_pkg::ST_FB_ADD: begin
            word_ff <= phaser_pkg::sat18(phaser_pkg::sext16(dry_ff)
                                         + phaser_pkg::sext16(phaser_pkg::q15_sat(prod_ff)));
         end
         phaser_pkg::ST_AP_ADD1: begin
            ap_ff <= phaser_pkg::sat18(phaser_pkg::sext16(phaser_pkg::q15_sat(prod_ff))
                                       + phaser_pkg::sext16(rd_mem));
         end
         phaser_pkg::ST_AP_ADD2: begin
            word_ff  <= ap_ff;
            stage_ff <= stage_ff + 1'b1;
         end
         phaser_pkg::ST_WET_ADD: begin
            v_ff <= phaser_pkg::sext16(dry_ff) + phaser_pkg::sext16(phaser_pkg::q15_sat(prod_ff));
         end
         phaser_pkg::ST_LIM_DIV: res_ff <= phaser_pkg::sat18(lim_v);
         default: begin
         end
      endcase
      if (cmd.rsp_load) begin
         rsp_out_sample_ff <= bypass_ff ? raw_ff : out_fmt;
      end
   end

   a_stage_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == phaser_pkg::ST_AP_MUL1) |-> (stage_ff < stages_eff))
      else $error("stage counter ran past the configured stage count");

   a_bypass_passes_raw: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_load && bypass_ff) |=> (rsp_out_sample_ff == $past(raw_ff)))
      else $error("bypassed sample was altered");

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the phaser all-pass cascade, with its own predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [phaser_pkg::CSR_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [phaser_pkg::CSR_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
   localparam longint KNEE_SCALE =
      64'sd65535 * (32768 - phaser_pkg::DEF_KNEE) / (65536 - phaser_pkg::DEF_KNEE);
   localparam int CYCLE_LIMIT = 1_000_000;

   logic                               clock;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic [15:0]                        req_in_sample = '0;
   logic                               req_right_channel = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic [15:0]                        rsp_out_sample;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [phaser_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [phaser_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   phaser_pkg::cfg_type shadow_cfg = '{
      stage_count:      phaser_pkg::RST_STAGE_COUNT,
      feedback_q15:     phaser_pkg::RST_FEEDBACK,
      mix_q15:          phaser_pkg::RST_MIX,
      allpass_coef_q15: phaser_pkg::RST_COEF,
      sixteen_bit:      1'b1,
      signed_samples:   1'b1
   };
   logic signed [15:0] fb_word [2] = '{default: '0};
   logic signed [15:0] ap_mem [2*phaser_pkg::DEF_MAX_STAGES] = '{default: '0};

   logic [15:0] expected_samples [$];
   logic [15:0] wanted;
   int          fail_count = 0;
   int          cycle_count = 0;
   int          req_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          rsp_hold_cycles = 0;

   phaser_allpass_cascade_top uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_sample     (req_in_sample),
      .req_right_channel (req_right_channel),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_sample    (rsp_out_sample),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint clip16(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint q15_product(input longint a, input longint b);
      longint p;
      p = a * b;
      return clip16(p >>> 15);
   endfunction

   function automatic longint knee_limit(input longint v);
      longint r;
      r = v;
      if (v < -phaser_pkg::DEF_KNEE) begin
         r = ((v + phaser_pkg::DEF_KNEE) * KNEE_SCALE) / 65535 - phaser_pkg::DEF_KNEE;
      end else if (v > phaser_pkg::DEF_KNEE) begin
         r = ((v - phaser_pkg::DEF_KNEE) * KNEE_SCALE) / 65535 + phaser_pkg::DEF_KNEE;
      end
      return clip16(r);
   endfunction

   function automatic logic [15:0] phaser_expect(input logic [15:0] raw_in,
                                                 input logic right);
      logic [15:0] raw;
      logic [15:0] flipped;
      longint      dry, fb, coef, word, ap, stored, res;
      int          n, base, j;
      raw = shadow_cfg.sixteen_bit ? raw_in : {8'h00, raw_in[7:0]};
      if (shadow_cfg.mix_q15 <= phaser_pkg::BYPASS_LIMIT) return raw;
      if (shadow_cfg.sixteen_bit) begin
         flipped = shadow_cfg.signed_samples ? raw : raw ^ phaser_pkg::SIGN_FLIP_16;
         dry = longint'($signed(flipped));
      end else begin
         flipped = {8'h00, shadow_cfg.signed_samples ? raw[7:0]
                                                     : raw[7:0] ^ phaser_pkg::SIGN_FLIP_8};
         dry = longint'($signed(flipped[7:0]));
      end
      fb = shadow_cfg.feedback_q15;
      if (fb < longint'(phaser_pkg::FB_MIN)) fb = phaser_pkg::FB_MIN;
      if (fb > longint'(phaser_pkg::FB_MAX)) fb = phaser_pkg::FB_MAX;
      coef = shadow_cfg.allpass_coef_q15;
      n = shadow_cfg.stage_count;
      if (n == 0) n = 1;
      if (n > phaser_pkg::DEF_MAX_STAGES) n = phaser_pkg::DEF_MAX_STAGES;
      base = right ? phaser_pkg::DEF_MAX_STAGES : 0;
      word = clip16(dry + q15_product(fb_word[right], fb));
      for (j = 0; j < n; j++) begin
         stored = ap_mem[base + j];
         ap = clip16(q15_product(word, -coef) + stored);
         ap_mem[base + j] = 16'(clip16(q15_product(ap, coef) + word));
         word = ap;
      end
      fb_word[right] = 16'(word);
      res = knee_limit(dry + q15_product(word, shadow_cfg.mix_q15));
      if (shadow_cfg.sixteen_bit) begin
         return 16'(res) ^ (shadow_cfg.signed_samples ? 16'h0000 : phaser_pkg::SIGN_FLIP_16);
      end
      return {8'h00, 8'(res) ^ (shadow_cfg.signed_samples ? 8'h00 : phaser_pkg::SIGN_FLIP_8)};
   endfunction

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(7))
         0: return $urandom_range(1) ? 16'h7fff : 16'h8000;
         1: return $urandom_range(1) ? 16'h0000 : 16'hffff;
         2: return 16'($urandom_range(0, 511)) - 16'd256;
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic push_sample(input logic [15:0] sample, input logic right);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_sample <= sample;
      req_right_channel <= right;
      do begin
         @(posedge clock);
      end while (!req_ready);
      expected_samples.push_back(phaser_expect(sample, right));
   endtask

   task automatic write_setting(input logic [phaser_pkg::CSR_INDEX_W-1:0] idx,
                                input logic [phaser_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      case (idx)
         phaser_pkg::REG_STAGE_COUNT: begin
            shadow_cfg.stage_count = data[4:0];
            ap_mem = '{default: '0};
         end
         phaser_pkg::REG_FEEDBACK:    shadow_cfg.feedback_q15 = data;
         phaser_pkg::REG_MIX:         shadow_cfg.mix_q15 = data;
         phaser_pkg::REG_COEF:        shadow_cfg.allpass_coef_q15 = data;
         phaser_pkg::REG_SIXTEEN_BIT: shadow_cfg.sixteen_bit = data[0];
         phaser_pkg::REG_SIGNED:      shadow_cfg.signed_samples = data[0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle_idle();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic reconfigure_random();
      logic [4:0] n;
      int         pick;
      settle_idle();
      pick = $urandom_range(99);
      if (pick < 70) n = 5'($urandom_range(1, 4));
      else if (pick < 85) n = 5'($urandom_range(0, 15));
      else n = 5'($urandom_range(16, 31));
      write_setting(phaser_pkg::REG_STAGE_COUNT, 15'(n));
      write_setting(phaser_pkg::REG_FEEDBACK, 15'($urandom_range(0, 32767)));
      if ($urandom_range(99) < 85) begin
         write_setting(phaser_pkg::REG_MIX,
                       15'($urandom_range(int'(phaser_pkg::BYPASS_LIMIT) + 1, 32767)));
      end else begin
         write_setting(phaser_pkg::REG_MIX,
                       15'($urandom_range(0, int'(phaser_pkg::BYPASS_LIMIT))));
      end
      write_setting(phaser_pkg::REG_COEF, 15'($urandom_range(0, 32767)));
      write_setting(phaser_pkg::REG_SIXTEEN_BIT, 15'($urandom_range(1)));
      write_setting(phaser_pkg::REG_SIGNED, 15'($urandom_range(1)));
      if ($urandom_range(3) == 0) begin
         write_setting($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
                       15'($urandom_range(0, 32767)));
      end
   endtask

   task automatic test_bypass_defaults();
      push_sample(16'h0000, 1'b0);
      push_sample(16'hffff, 1'b1);
      push_sample(16'h8000, 1'b0);
      push_sample(16'h7fff, 1'b1);
   endtask

   task automatic test_extremes();
      settle_idle();
      write_setting(phaser_pkg::REG_STAGE_COUNT, 15'd31);
      write_setting(phaser_pkg::REG_FEEDBACK, 15'h7fff);
      write_setting(phaser_pkg::REG_MIX, 15'h7fff);
      write_setting(phaser_pkg::REG_COEF, 15'h7fff);
      write_setting(phaser_pkg::REG_SIXTEEN_BIT, 15'd1);
      write_setting(phaser_pkg::REG_SIGNED, 15'd1);
      repeat (3) push_sample(16'h7fff, 1'b0);
      repeat (3) push_sample(16'h8000, 1'b1);
      settle_idle();
      write_setting(phaser_pkg::REG_STAGE_COUNT, 15'd0);
      write_setting(phaser_pkg::REG_FEEDBACK, 15'd0);
      write_setting(phaser_pkg::REG_COEF, 15'd0);
      write_setting(phaser_pkg::REG_SIXTEEN_BIT, 15'd0);
      write_setting(phaser_pkg::REG_SIGNED, 15'd0);
      push_sample(16'h00ff, 1'b0);
      push_sample(16'hff00, 1'b1);
      push_sample(16'h0080, 1'b0);
      push_sample(16'h127f, 1'b1);
   endtask

   task automatic test_bypass_edge();
      settle_idle();
      write_setting(REG_SPARE_LO, 15'h7fff);
      write_setting(REG_SPARE_HI, 15'h0000);
      write_setting(phaser_pkg::REG_MIX, phaser_pkg::BYPASS_LIMIT);
      push_sample(16'hff80, 1'b1);
      settle_idle();
      write_setting(phaser_pkg::REG_MIX, phaser_pkg::BYPASS_LIMIT + 15'd1);
      write_setting(phaser_pkg::REG_SIXTEEN_BIT, 15'd1);
      push_sample(16'h0000, 1'b0);
      push_sample(16'hffff, 1'b1);
      push_sample(16'h8001, 1'b0);
   endtask

   task automatic test_backpressure();
      settle_idle();
      write_setting(phaser_pkg::REG_STAGE_COUNT, 15'd16);
      write_setting(phaser_pkg::REG_MIX, 15'd20000);
      write_setting(phaser_pkg::REG_COEF, 15'd12000);
      write_setting(phaser_pkg::REG_SIGNED, 15'd1);
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold_cycles = 400;
      repeat (12) push_sample(pick_sample(), 1'($urandom_range(1)));
      settle_idle();
   endtask

   task automatic test_random_traffic();
      int m, b, k;
      for (m = 0; m < 4; m++) begin
         case (m)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 58; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 58; end
            default: begin req_idle_pct = 31; rsp_stall_pct = 31; end
         endcase
         for (b = 0; b < 4; b++) begin
            reconfigure_random();
            for (k = 0; k < 40; k++) push_sample(pick_sample(), 1'($urandom_range(1)));
         end
      end
   endtask

   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_cycles = rsp_hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            $display("%0t: out_sample with no transfer pending: expected none, actual %h",
                     $time, rsp_out_sample);
            fail_count++;
         end else begin
            wanted = expected_samples.pop_front();
            if (rsp_out_sample !== wanted) begin
               $display("%0t: out_sample mismatch: expected %h, actual %h",
                        $time, wanted, rsp_out_sample);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_bypass_defaults();
      test_extremes();
      test_bypass_edge();
      test_backpressure();
      test_random_traffic();
      settle_idle();
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

// File: filelist.f
hw/rtl/phaser_pkg.sv
hw/rtl/phaser_ctrl.sv
hw/rtl/phaser_dp.sv
hw/rtl/phaser_allpass_cascade_top.sv
sim/tb_top.sv
